/* hw/rtl/kvt_pkg.sv */
package kvt_pkg;

   // position counters and result field widths
   localparam int POS_BITS = 24;
   localparam int OUT_BITS = 24;
   localparam int EXT_BITS = POS_BITS + OUT_BITS;
   localparam int KIND_BITS = 4;
   localparam int CLS_BITS = 4;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;
   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

   // queue between front and back
   localparam int IQ_DEPTH = 4;
   localparam int IQ_AW = $clog2(IQ_DEPTH);
   localparam int IQ_CW = $clog2(IQ_DEPTH + 1);

   // result buffer in the back end
   localparam int RQ_DEPTH = 4;
   localparam int RQ_AW = $clog2(RQ_DEPTH);
   localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

   // token kinds; the pending mode uses the same codes plus idle and comment
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_END     = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_SPACE   = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_NEWLINE = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_STRING  = 4'd11;
   localparam logic [KIND_BITS-1:0] MODE_IDLE    = 4'd0;
   localparam logic [KIND_BITS-1:0] MODE_COMMENT = 4'd12;

   // byte classes produced by the front end
   localparam logic [CLS_BITS-1:0] CLS_OTHER  = 4'd0;
   localparam logic [CLS_BITS-1:0] CLS_NUL    = 4'd1;
   localparam logic [CLS_BITS-1:0] CLS_LF     = 4'd2;
   localparam logic [CLS_BITS-1:0] CLS_CR     = 4'd3;
   localparam logic [CLS_BITS-1:0] CLS_SPACE  = 4'd4;
   localparam logic [CLS_BITS-1:0] CLS_HASH   = 4'd5;
   localparam logic [CLS_BITS-1:0] CLS_QUOTE  = 4'd6;
   localparam logic [CLS_BITS-1:0] CLS_BSLASH = 4'd7;
   localparam logic [CLS_BITS-1:0] CLS_ASSIGN = 4'd8;
   localparam logic [CLS_BITS-1:0] CLS_COMMA  = 4'd9;
   localparam logic [CLS_BITS-1:0] CLS_LBRACK = 4'd10;
   localparam logic [CLS_BITS-1:0] CLS_RBRACK = 4'd11;
   localparam logic [CLS_BITS-1:0] CLS_LBRACE = 4'd12;
   localparam logic [CLS_BITS-1:0] CLS_RBRACE = 4'd13;
   localparam logic [CLS_BITS-1:0] CLS_IDENT  = 4'd14;
   localparam logic [CLS_BITS-1:0] CLS_COLON  = 4'd15;

   typedef logic [POS_BITS-1:0] pos_type;

   typedef struct packed {
      logic [CLS_BITS-1:0] cls;
      logic                last;
   } item_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [OUT_BITS-1:0]  start;
      logic [OUT_BITS-1:0]  length;
      logic [OUT_BITS-1:0]  line;
      logic [OUT_BITS-1:0]  column;
      logic                 unclosed;
      logic                 last;
   } result_type;

endpackage

/* hw/rtl/kvt_front.sv */
module kvt_front
   import kvt_pkg::*;
(
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [7:0] req_byte_value,
   input  logic     req_last_byte,
   output logic     push_valid,
   input  logic     push_ready,
   output item_type push_item
);

   // map one source byte to its lexical class
   function automatic logic [CLS_BITS-1:0] classify(logic [7:0] b);
      logic alnum;
      alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
              (b >= 8'h41 && b <= 8'h5A);
      case (b)
         8'h00: return CLS_NUL;
         8'h0A: return CLS_LF;
         8'h0D: return CLS_CR;
         8'h20, 8'h09: return CLS_SPACE;   // space, tab
         8'h23: return CLS_HASH;           // '#'
         8'h22: return CLS_QUOTE;          // '"'
         8'h5C: return CLS_BSLASH;         // backslash
         8'h3D: return CLS_ASSIGN;         // '='
         8'h2C: return CLS_COMMA;          // ','
         8'h5B: return CLS_LBRACK;         // '['
         8'h5D: return CLS_RBRACK;         // ']'
         8'h7B: return CLS_LBRACE;         // '{'
         8'h7D: return CLS_RBRACE;         // '}'
         8'h3A: return CLS_COLON;          // ':'
         8'h5F, 8'h2E, 8'h2D, 8'h2B: return CLS_IDENT;  // _ . - +
         default: return alnum ? CLS_IDENT : CLS_OTHER;
      endcase
   endfunction

   // classified byte goes straight into the queue
   assign push_valid     = req_valid;
   assign req_ready      = push_ready;
   assign push_item.cls  = classify(req_byte_value);
   assign push_item.last = req_last_byte;

endmodule

/* hw/rtl/kvt_queue.sv */
module kvt_queue
   import kvt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type           slot_ff [IQ_DEPTH];
   item_type           slot_in [IQ_DEPTH];
   logic [IQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IQ_CW-1:0]   cnt_ff, cnt_in;
   logic               push, pop;

   function automatic logic [IQ_AW-1:0] next_ptr(logic [IQ_AW-1:0] p);
      return (p == IQ_AW'(IQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (cnt_ff != IQ_CW'(IQ_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      slot_in = slot_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_item;
      end
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + IQ_CW'(push) - IQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* hw/rtl/kvt_back.sv */
module kvt_back
   import kvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   output logic       item_ready,
   input  item_type   item,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   // lexer state
   logic [KIND_BITS-1:0] mode_ff, mode_in;
   pos_type              start_ff, start_in;
   pos_type              len_ff, len_in;
   pos_type              line_ff, line_in;
   pos_type              col_ff, col_in;
   logic                 esc_ff, esc_in;
   pos_type              off_ff, off_in;
   pos_type              lines_ff, lines_in;
   pos_type              lbegin_ff, lbegin_in;
   logic                 ended_ff, ended_in;

   // result buffer
   result_type           rq_ff [RQ_DEPTH];
   result_type           rq_in [RQ_DEPTH];
   logic [RQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [RQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RQ_CW-1:0]     cnt_ff, cnt_in;

   logic                 take, pop, consumed, nl_fin;
   logic [1:0]           nres;
   result_type           r0, r1;

   function automatic pos_type sat_inc(pos_type v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic pos_type sat_add(pos_type a, pos_type b);
      logic [POS_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
   endfunction

   // a + b + 1, saturating
   function automatic pos_type sat_add_inc(pos_type a, pos_type b);
      logic [POS_BITS+1:0] s;
      s = (POS_BITS+2)'(a) + (POS_BITS+2)'(b) + (POS_BITS+2)'(1);
      return (s > (POS_BITS+2)'(POS_MAX)) ? POS_MAX : s[POS_BITS-1:0];
   endfunction

   function automatic logic [OUT_BITS-1:0] clip_out(pos_type v);
      logic [EXT_BITS-1:0] w;
      w = EXT_BITS'(v);
      return (w > EXT_BITS'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
   endfunction

   function automatic logic [KIND_BITS-1:0] run_kind(logic [CLS_BITS-1:0] c);
      case (c)
         CLS_ASSIGN: return KIND_ASSIGN;
         CLS_COMMA:  return KIND_COMMA;
         CLS_LBRACK: return KIND_LBRACK;
         CLS_RBRACK: return KIND_RBRACK;
         CLS_LBRACE: return KIND_LBRACE;
         CLS_RBRACE: return KIND_RBRACE;
         default:    return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic result_type mk(logic [KIND_BITS-1:0] k, pos_type s, pos_type l,
                                     pos_type ln, pos_type c, logic u);
      result_type r;
      r.kind     = k;
      r.start    = clip_out(s);
      r.length   = clip_out(l);
      r.line     = clip_out(ln);
      r.column   = clip_out(c);
      r.unclosed = u;
      r.last     = 1'b0;
      return r;
   endfunction

   function automatic logic [RQ_AW-1:0] next_ptr(logic [RQ_AW-1:0] p);
      return (p == RQ_AW'(RQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // take an item only when two result slots are free
   assign item_ready = (cnt_ff <= RQ_CW'(RQ_DEPTH - 2));
   assign take       = item_valid && item_ready;
   assign res_valid  = (cnt_ff != '0);
   assign res        = rq_ff[rd_ptr_ff];
   assign pop        = res_valid && res_ready;

   // lexer step for one byte class
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      esc_in    = esc_ff;
      off_in    = off_ff;
      lines_in  = lines_ff;
      lbegin_in = lbegin_ff;
      ended_in  = ended_ff;
      consumed  = 1'b0;
      nl_fin    = 1'b0;
      nres      = 2'd0;
      r0        = '0;
      r1        = '0;

      if (take && ended_ff) begin
         // after an end token everything up to the last byte is ignored
         if (item.last) begin
            mode_in   = MODE_IDLE;
            start_in  = '0;
            len_in    = '0;
            line_in   = POS_BITS'(1);
            col_in    = POS_BITS'(1);
            esc_in    = 1'b0;
            off_in    = '0;
            lines_in  = '0;
            lbegin_in = '0;
            ended_in  = 1'b0;
         end
      end else if (take) begin
         // does the pending token absorb this byte
         case (mode_ff)
            KIND_SPACE:   consumed = (item.cls == CLS_SPACE);
            KIND_NEWLINE: consumed = (item.cls == CLS_LF) || (item.cls == CLS_CR);
            KIND_ASSIGN, KIND_COMMA, KIND_LBRACK, KIND_RBRACK, KIND_LBRACE, KIND_RBRACE:
               consumed = (run_kind(item.cls) == mode_ff);
            KIND_IDENT:   consumed = (item.cls == CLS_IDENT) || (item.cls == CLS_COLON);
            KIND_STRING: begin
               consumed = 1'b1;
               len_in   = sat_inc(len_ff);
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (item.cls == CLS_BSLASH) begin
                  esc_in = 1'b1;
               end else if ((item.cls == CLS_LF) || (item.cls == CLS_CR)) begin
                  r0      = mk(KIND_STRING, start_ff, len_in, line_ff, col_ff, 1'b1);
                  nres    = 2'd1;
                  mode_in = MODE_IDLE;
               end else if (item.cls == CLS_QUOTE) begin
                  r0      = mk(KIND_STRING, start_ff, len_in, line_ff, col_ff, 1'b0);
                  nres    = 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_COMMENT: begin
               consumed = (item.cls != CLS_LF);
               if (!consumed) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase

         if (consumed) begin
            if (mode_in != KIND_STRING && mode_in != MODE_IDLE) begin
               len_in = sat_inc(len_ff);
            end
         end else begin
            // flush the pending token
            if (mode_in == KIND_STRING) begin
               r0   = mk(KIND_STRING, start_ff, len_ff, line_ff, col_ff, 1'b1);
               nres = 2'd1;
            end else if (mode_in != MODE_IDLE && mode_in != MODE_COMMENT) begin
               r0   = mk(mode_in, start_ff, len_ff, line_ff, col_ff, 1'b0);
               nres = 2'd1;
               if (mode_in == KIND_NEWLINE) begin
                  nl_fin    = 1'b1;
                  lines_in  = sat_add(lines_ff, len_ff);
                  lbegin_in = off_ff;
               end
            end
            // open a token at this byte
            start_in = off_ff;
            len_in   = POS_BITS'(1);
            line_in  = nl_fin ? sat_add_inc(lines_ff, len_ff) : sat_inc(lines_ff);
            col_in   = nl_fin ? POS_BITS'(1) : sat_inc(off_ff - lbegin_ff);
            esc_in   = 1'b0;
            mode_in  = MODE_IDLE;
            case (item.cls)
               CLS_NUL: begin
                  if (nres == 2'd0) begin
                     r0 = mk(KIND_END, start_in, POS_BITS'(1), line_in, col_in, 1'b0);
                  end else begin
                     r1 = mk(KIND_END, start_in, POS_BITS'(1), line_in, col_in, 1'b0);
                  end
                  nres     = nres + 2'd1;
                  ended_in = 1'b1;
               end
               CLS_LF, CLS_CR: mode_in = KIND_NEWLINE;
               CLS_SPACE:      mode_in = KIND_SPACE;
               CLS_HASH:       mode_in = MODE_COMMENT;
               CLS_QUOTE:      mode_in = KIND_STRING;
               CLS_ASSIGN, CLS_COMMA, CLS_LBRACK, CLS_RBRACK, CLS_LBRACE, CLS_RBRACE:
                  mode_in = run_kind(item.cls);
               CLS_IDENT:      mode_in = KIND_IDENT;
               default: begin
                  if (nres == 2'd0) begin
                     r0 = mk(KIND_UNKNOWN, start_in, POS_BITS'(1), line_in, col_in, 1'b0);
                  end else begin
                     r1 = mk(KIND_UNKNOWN, start_in, POS_BITS'(1), line_in, col_in, 1'b0);
                  end
                  nres = nres + 2'd1;
               end
            endcase
         end

         off_in = sat_inc(off_ff);

         // last byte: flush and start over
         if (item.last) begin
            if (mode_in == KIND_STRING) begin
               if (nres == 2'd0) begin
                  r0 = mk(KIND_STRING, start_in, len_in, line_in, col_in, 1'b1);
               end else begin
                  r1 = mk(KIND_STRING, start_in, len_in, line_in, col_in, 1'b1);
               end
               nres = nres + 2'd1;
            end else if (mode_in != MODE_IDLE && mode_in != MODE_COMMENT) begin
               if (nres == 2'd0) begin
                  r0 = mk(mode_in, start_in, len_in, line_in, col_in, 1'b0);
               end else begin
                  r1 = mk(mode_in, start_in, len_in, line_in, col_in, 1'b0);
               end
               nres = nres + 2'd1;
            end
            mode_in   = MODE_IDLE;
            start_in  = '0;
            len_in    = '0;
            line_in   = POS_BITS'(1);
            col_in    = POS_BITS'(1);
            esc_in    = 1'b0;
            off_in    = '0;
            lines_in  = '0;
            lbegin_in = '0;
            ended_in  = 1'b0;
         end
      end

      // tag the final result of this byte
      if (nres == 2'd1) begin
         r0.last = 1'b1;
      end else if (nres == 2'd2) begin
         r1.last = 1'b1;
      end
   end

   // result buffer: up to two writes, one read per cycle
   always_comb begin
      rq_in = rq_ff;
      if (nres != 2'd0) begin
         rq_in[wr_ptr_ff] = r0;
      end
      if (nres == 2'd2) begin
         rq_in[next_ptr(wr_ptr_ff)] = r1;
      end
      case (nres)
         2'd1:    wr_ptr_in = next_ptr(wr_ptr_ff);
         2'd2:    wr_ptr_in = next_ptr(next_ptr(wr_ptr_ff));
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + RQ_CW'(nres) - RQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in;
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         len_ff    <= '0;
         line_ff   <= POS_BITS'(1);
         col_ff    <= POS_BITS'(1);
         esc_ff    <= 1'b0;
         off_ff    <= '0;
         lines_ff  <= '0;
         lbegin_ff <= '0;
         ended_ff  <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         esc_ff    <= esc_in;
         off_ff    <= off_in;
         lines_ff  <= lines_in;
         lbegin_ff <= lbegin_in;
         ended_ff  <= ended_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* hw/rtl/key_value_text_tokenizer.sv */
// Takes one byte per cycle while the byte queue has room; a token leaves after the byte that
// ends it (the next byte of another class, or the last byte) passes queue and result buffer.
// Each result takes one rsp_ transfer; a byte that ends two tokens writes both into the
// four-entry result buffer, whose single read port hands them out one at a time.
// Synchronous active-high reset empties the byte queue and the result buffer and puts the
// lexer at the start of a new text (offset 0, line 1, column 1).
module key_value_text_tokenizer
   import kvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_BITS-1:0] rsp_token_kind,
   output logic [OUT_BITS-1:0]  rsp_start_offset,
   output logic [OUT_BITS-1:0]  rsp_token_length,
   output logic [OUT_BITS-1:0]  rsp_line_number,
   output logic [OUT_BITS-1:0]  rsp_column_number,
   output logic                 rsp_unclosed_string,
   output logic                 rsp_last_result
);

   logic       push_valid, push_ready;
   item_type   push_item;
   logic       pop_valid, pop_ready;
   item_type   pop_item;
   result_type res;

   // classify incoming bytes
   kvt_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   // decouple front from back
   kvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // token state machine and result buffer
   kvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .res_valid  (rsp_valid),
      .res_ready  (rsp_ready),
      .res        (res)
   );

   assign rsp_token_kind      = res.kind;
   assign rsp_start_offset    = res.start;
   assign rsp_token_length    = res.length;
   assign rsp_line_number     = res.line;
   assign rsp_column_number   = res.column;
   assign rsp_unclosed_string = res.unclosed;
   assign rsp_last_result     = res.last;

`ifndef SYNTH
   // both sides come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("queues not empty after reset");

   // only string tokens can be flagged unclosed
   a_unclosed_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unclosed_string) |-> (rsp_token_kind == KIND_STRING))
      else $error("unclosed flag on non-string token");

   // end token is a single byte
   a_end_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == KIND_END) |->
         (rsp_token_length == OUT_BITS'(1) && !rsp_unclosed_string))
      else $error("end token with bad length");

   // positions are one-based and lengths nonzero
   a_positions: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0 && rsp_column_number != '0 &&
                     rsp_token_length != '0))
      else $error("zero line, column or length");
`endif

endmodule

/* test/key_value_text_tokenizer_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts the token stream of every accepted byte
// and compares each result transfer against the oldest predicted token.
module key_value_text_tokenizer_checker
   import kvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_last_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [KIND_BITS-1:0] rsp_token_kind,
   input  logic [OUT_BITS-1:0]  rsp_start_offset,
   input  logic [OUT_BITS-1:0]  rsp_token_length,
   input  logic [OUT_BITS-1:0]  rsp_line_number,
   input  logic [OUT_BITS-1:0]  rsp_column_number,
   input  logic                 rsp_unclosed_string,
   input  logic                 rsp_last_result,
   output int                   error_count,
   output int                   results_owed
);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam pos_type POS_ONE = pos_type'(1);

   // predicted tokens not yet seen on the result port
   result_type tokens_due[$];

   // lexer state as the block should hold it
   logic [KIND_BITS-1:0] cur_mode;
   pos_type              tok_start;
   pos_type              tok_len;
   pos_type              tok_line;
   pos_type              tok_col;
   logic                 in_escape;
   pos_type              byte_pos;
   pos_type              lines_done;
   pos_type              line_base;
   logic                 text_ended;

   function automatic pos_type clamp_add(pos_type v, pos_type by);
      logic [POS_BITS:0] sum;
      sum = {1'b0, v} + {1'b0, by};
      return (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_BITS-1:0];
   endfunction

   function automatic logic is_eol(logic [7:0] b);
      return (b == CH_LF) || (b == CH_CR);
   endfunction

   function automatic logic is_blank(logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB);
   endfunction

   function automatic logic ident_start(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")
         || b == "_" || b == "." || b == "-" || b == "+";
   endfunction

   function automatic logic [KIND_BITS-1:0] run_kind_of(logic [7:0] b);
      case (b)
         "=":     return KIND_ASSIGN;
         ",":     return KIND_COMMA;
         "[":     return KIND_LBRACK;
         "]":     return KIND_RBRACK;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   task automatic clear_state();
      cur_mode   = MODE_IDLE;
      tok_start  = '0;
      tok_len    = '0;
      tok_line   = POS_ONE;
      tok_col    = POS_ONE;
      in_escape  = 1'b0;
      byte_pos   = '0;
      lines_done = '0;
      line_base  = '0;
      text_ended = 1'b0;
   endtask

   task automatic push_token(logic [KIND_BITS-1:0] kind, pos_type len, logic open_str);
      result_type t;
      t.kind     = kind;
      t.start    = tok_start;
      t.length   = len;
      t.line     = tok_line;
      t.column   = tok_col;
      t.unclosed = open_str;
      t.last     = 1'b0;
      tokens_due.insert(tokens_due.size(), t);
   endtask

   // close the pending token; comments vanish, strings are open here
   task automatic flush_token();
      if (cur_mode == KIND_STRING) begin
         push_token(KIND_STRING, tok_len, 1'b1);
      end else if (cur_mode != MODE_IDLE && cur_mode != MODE_COMMENT) begin
         push_token(cur_mode, tok_len, 1'b0);
         if (cur_mode == KIND_NEWLINE) begin
            lines_done = clamp_add(lines_done, tok_len);
            line_base  = byte_pos;
         end
      end
      cur_mode  = MODE_IDLE;
      in_escape = 1'b0;
   endtask

   task automatic lex_byte(logic [7:0] b, logic last_in);
      logic taken;
      int   base;
      base  = tokens_due.size();
      taken = 1'b0;

      // after an end token everything up to the last byte is ignored
      if (text_ended) begin
         if (last_in) clear_state();
         return;
      end

      // does the byte extend the pending token
      case (cur_mode)
         KIND_SPACE: taken = is_blank(b);
         KIND_NEWLINE: taken = is_eol(b);
         KIND_ASSIGN, KIND_COMMA, KIND_LBRACK, KIND_RBRACK, KIND_LBRACE, KIND_RBRACE:
            taken = (run_kind_of(b) == cur_mode);
         KIND_IDENT: taken = ident_start(b) || b == ":";
         KIND_STRING: begin
            taken   = 1'b1;
            tok_len = clamp_add(tok_len, POS_ONE);
            if (in_escape) begin
               in_escape = 1'b0;
            end else if (b == CH_BSLASH) begin
               in_escape = 1'b1;
            end else if (is_eol(b)) begin
               push_token(KIND_STRING, tok_len, 1'b1);
               cur_mode = MODE_IDLE;
            end else if (b == CH_QUOTE) begin
               push_token(KIND_STRING, tok_len, 1'b0);
               cur_mode = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            taken = (b != CH_LF);
            if (!taken) cur_mode = MODE_IDLE;
         end
         default: cur_mode = MODE_IDLE;
      endcase

      // otherwise the byte opens a new token
      if (taken) begin
         if (cur_mode != KIND_STRING && cur_mode != MODE_IDLE) begin
            tok_len = clamp_add(tok_len, POS_ONE);
         end
      end else begin
         flush_token();
         tok_start = byte_pos;
         tok_len   = POS_ONE;
         tok_line  = clamp_add(lines_done, POS_ONE);
         tok_col   = clamp_add(byte_pos - line_base, POS_ONE);
         in_escape = 1'b0;
         if (b == CH_NUL) begin
            push_token(KIND_END, POS_ONE, 1'b0);
            text_ended = 1'b1;
         end else if (is_eol(b)) begin
            cur_mode = KIND_NEWLINE;
         end else if (is_blank(b)) begin
            cur_mode = KIND_SPACE;
         end else if (b == CH_HASH) begin
            cur_mode = MODE_COMMENT;
         end else if (b == CH_QUOTE) begin
            cur_mode = KIND_STRING;
         end else if (run_kind_of(b) != KIND_UNKNOWN) begin
            cur_mode = run_kind_of(b);
         end else if (ident_start(b)) begin
            cur_mode = KIND_IDENT;
         end else begin
            push_token(KIND_UNKNOWN, POS_ONE, 1'b0);
         end
      end

      byte_pos = clamp_add(byte_pos, POS_ONE);

      if (last_in) begin
         flush_token();
         clear_state();
      end
      if (tokens_due.size() > base) tokens_due[$].last = 1'b1;
   endtask

   task automatic check_field(string name, logic [OUT_BITS-1:0] want, logic [OUT_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_token();
      result_type want;
      if (tokens_due.size() == 0) begin
         $error("token_kind: expected none, got %0d (start %0d)", rsp_token_kind,
            rsp_start_offset);
         error_count++;
      end else begin
         want = tokens_due.pop_front();
         check_field("token_kind", OUT_BITS'(want.kind), OUT_BITS'(rsp_token_kind));
         check_field("start_offset", want.start, rsp_start_offset);
         check_field("token_length", want.length, rsp_token_length);
         check_field("line_number", want.line, rsp_line_number);
         check_field("column_number", want.column, rsp_column_number);
         check_field("unclosed_string", OUT_BITS'(want.unclosed),
            OUT_BITS'(rsp_unclosed_string));
         check_field("last_result", OUT_BITS'(want.last), OUT_BITS'(rsp_last_result));
      end
   endtask

   // compare result transfers, then predict from byte transfers
   always @(posedge clock) begin
      if (reset) begin
         tokens_due.delete();
         clear_state();
      end else begin
         if (rsp_valid && rsp_ready) check_token();
         if (req_valid && req_ready) lex_byte(req_byte_value, req_last_byte);
      end
      results_owed = tokens_due.size();
   end

endmodule

/* test/key_value_text_tokenizer_test.sv */
`timescale 1ns / 1ps

module key_value_text_tokenizer_test;
   import kvt_pkg::*;

   localparam int RANDOM_ITEMS     = 1650;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int SINK_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 20;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HIGH  = 8'h80;
   localparam logic [7:0] CH_TOP   = 8'hFF;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_byte_value;
   logic                 req_last_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [KIND_BITS-1:0] rsp_token_kind;
   logic [OUT_BITS-1:0]  rsp_start_offset;
   logic [OUT_BITS-1:0]  rsp_token_length;
   logic [OUT_BITS-1:0]  rsp_line_number;
   logic [OUT_BITS-1:0]  rsp_column_number;
   logic                 rsp_unclosed_string;
   logic                 rsp_last_result;

   int         error_total;
   int         results_owed;
   int         src_idle_pct;
   int         sink_idle_pct;
   bit         sink_hold_req;
   int         cycle_count = 0;
   int         item_count;
   logic [7:0] text_bytes[$];
   string      ident_punct = "_.-+";

   key_value_text_tokenizer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_value      (req_byte_value),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_token_kind      (rsp_token_kind),
      .rsp_start_offset    (rsp_start_offset),
      .rsp_token_length    (rsp_token_length),
      .rsp_line_number     (rsp_line_number),
      .rsp_column_number   (rsp_column_number),
      .rsp_unclosed_string (rsp_unclosed_string),
      .rsp_last_result     (rsp_last_result)
   );

   key_value_text_tokenizer_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_value      (req_byte_value),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_token_kind      (rsp_token_kind),
      .rsp_start_offset    (rsp_start_offset),
      .rsp_token_length    (rsp_token_length),
      .rsp_line_number     (rsp_line_number),
      .rsp_column_number   (rsp_column_number),
      .rsp_unclosed_string (rsp_unclosed_string),
      .rsp_last_result     (rsp_last_result),
      .error_count         (error_total),
      .results_owed        (results_owed)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
         end
      end
   end

   // append one byte to the text being built
   task automatic put_byte(logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endtask

   task automatic add_str(string s);
      foreach (s[i]) put_byte(s[i]);
   endtask

   task automatic add_ident();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 4))
            0: put_byte(8'("a" + $urandom_range(0, 25)));
            1: put_byte(8'("A" + $urandom_range(0, 25)));
            2: put_byte(8'("0" + $urandom_range(0, 9)));
            3: put_byte(ident_punct[$urandom_range(0, 3)]);
            default: put_byte(i == 0 ? "_" : ":");
         endcase
      end
   endtask

   task automatic add_blank();
      repeat ($urandom_range(0, 3)) put_byte($urandom_range(0, 1) ? " " : CH_TAB);
   endtask

   task automatic add_eol();
      case ($urandom_range(0, 4))
         0, 1: put_byte(CH_LF);
         2: begin
            put_byte(CH_CR);
            put_byte(CH_LF);
         end
         3: begin
            put_byte(CH_LF);
            put_byte(CH_LF);
         end
         default: put_byte(CH_CR);
      endcase
   endtask

   // quoted string with escapes; sometimes cut by a line end or left open
   task automatic add_string();
      put_byte(CH_QUOTE);
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 5))
            0, 1: put_byte(8'("a" + $urandom_range(0, 25)));
            2: begin
               put_byte("\\");
               put_byte(8'($urandom_range(0, 255)));
            end
            3: put_byte(8'($urandom_range(1, 255)));
            4: put_byte(" ");
            default: put_byte(8'($urandom_range(0, 255)));
         endcase
      end
      case ($urandom_range(0, 19))
         0, 1: put_byte(CH_LF);
         2: ;
         default: put_byte(CH_QUOTE);
      endcase
   endtask

   // one text, last flag on its final byte
   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) begin
         while ($urandom_range(0, 99) < src_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid      <= 1'b1;
         req_byte_value <= text_bytes[i];
         req_last_byte  <= (i == text_bytes.size() - 1);
         do @(posedge clock); while (!req_ready);
      end
   endtask

   task automatic wait_results();
      do @(posedge clock); while (results_owed != 0);
   endtask

   initial begin
      bit hold_started;
      bit pause_done;
      int tail_ignored;
      hold_started   = 1'b0;
      pause_done     = 1'b0;
      item_count     = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_byte_value = '0;
      req_last_byte  = 1'b0;
      src_idle_pct   = 12;
      sink_idle_pct  = 77;
      sink_hold_req  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: key with colon, escaped quote, CR LF run, comment
      text_bytes.delete();
      add_str("k:v=\"a\\\"b\"");
      put_byte(CH_CR);
      put_byte(CH_LF);
      add_str("#c");
      put_byte(CH_LF);
      send_text();

      // directed: blank run, bracket runs, high bytes, string cut at LF, open at end
      text_bytes.delete();
      add_str(" \t[[,]{}");
      put_byte(CH_TOP);
      put_byte(CH_HIGH);
      add_str("\"s");
      put_byte(CH_LF);
      add_str("\"o");
      send_text();

      // directed: NUL ends the text, rest ignored up to the last byte
      text_bytes.delete();
      add_str("k");
      put_byte(CH_NUL);
      add_str("z");
      put_byte(CH_TOP);
      send_text();

      // random config-style texts with noise and broken pieces
      while (item_count < RANDOM_ITEMS) begin
         if (item_count < 550) begin
            src_idle_pct  = 12;
            sink_idle_pct = 77;
         end else if (item_count < 1100) begin
            src_idle_pct  = 77;
            sink_idle_pct = 12;
         end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         if (!hold_started && item_count >= 300) begin
            hold_started  = 1'b1;
            sink_hold_req = 1'b1;
         end
         if (!pause_done && item_count >= 800) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            wait_results();
         end

         text_bytes.delete();
         tail_ignored = 0;
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // key = value [# comment]
                  add_ident();
                  add_blank();
                  put_byte("=");
                  if ($urandom_range(0, 7) == 0) put_byte("=");
                  add_blank();
                  case ($urandom_range(0, 4))
                     0: add_ident();
                     1: add_string();
                     2: begin
                        put_byte("[");
                        add_ident();
                        put_byte(",");
                        add_blank();
                        add_ident();
                        put_byte("]");
                     end
                     3: begin
                        put_byte("{");
                        add_ident();
                        put_byte("=");
                        add_string();
                        put_byte("}");
                     end
                     default: begin
                        put_byte("[");
                        put_byte("]");
                     end
                  endcase
                  if ($urandom_range(0, 3) == 0) begin
                     add_blank();
                     put_byte("#");
                     add_ident();
                  end
                  add_eol();
               end
               4: begin
                  // section header, single or double brackets
                  tail_ignored = $urandom_range(0, 1);
                  put_byte("[");
                  if (tail_ignored != 0) put_byte("[");
                  add_ident();
                  put_byte("]");
                  if (tail_ignored != 0) put_byte("]");
                  tail_ignored = 0;
                  add_eol();
               end
               5: begin
                  // comment line with arbitrary content
                  put_byte("#");
                  repeat ($urandom_range(0, 5)) begin
                     tail_ignored = $urandom_range(0, 255);
                     put_byte(tail_ignored == CH_LF ? "x" : 8'(tail_ignored));
                  end
                  tail_ignored = 0;
                  add_eol();
               end
               6: begin
                  add_blank();
                  add_eol();
               end
               7: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(1, 255)));
               8: begin
                  repeat ($urandom_range(1, 3)) put_byte(",");
                  repeat ($urandom_range(1, 2)) put_byte("{");
                  repeat ($urandom_range(1, 2)) put_byte("}");
               end
               default: begin
                  add_string();
                  add_eol();
               end
            endcase
         end
         // occasionally cut the text short
         if ($urandom_range(0, 9) == 0)
            text_bytes = text_bytes[0:$urandom_range(0, text_bytes.size() - 1)];
         // occasionally end it early with a NUL
         if ($urandom_range(0, 14) == 0) begin
            put_byte(CH_NUL);
            tail_ignored = $urandom_range(0, 2);
            repeat (tail_ignored) put_byte(8'($urandom_range(0, 255)));
         end
         item_count += text_bytes.size() - tail_ignored;
         send_text();
      end

      req_valid <= 1'b0;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_total == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
